// ----- hw/rtl/rbmd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbmd_pkg: shared definitions for the ring buffer marker deframer
// Types, codes and default sizes used by the sequencer, the ring memory,
// the top level and the checker.
// ----------------------------------------------------------------------------
package rbmd_pkg;

  // default sizes
  localparam int unsigned RING_DEPTH_DEF = 256;
  localparam int unsigned MAX_MSG_DEF    = 32;

  // fixed field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned START_BIT = 7;

  // command codes
  localparam logic CMD_APPEND  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  // result status codes
  localparam logic STS_OK   = 1'b0;
  localparam logic STS_FAIL = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EMIT_RD,
    ST_EMIT_CHK,
    ST_FAIL,
    ST_OUT
  } rbmd_state_e;

endpackage

// ----- hw/rtl/rbmd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbmd_ram: ring storage
// Single write port and single read port, read data registered.
// Entries hold whatever was last written; no reset.
// ----------------------------------------------------------------------------
module rbmd_ram #(
  parameter int unsigned RingDepth = rbmd_pkg::RING_DEPTH_DEF,
  localparam int unsigned PtrW     = $clog2(RingDepth)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [PtrW-1:0]             waddr_i,
  input  logic [rbmd_pkg::BYTE_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [PtrW-1:0]             raddr_i,
  output logic [rbmd_pkg::BYTE_W-1:0] rdata_o
);

  logic [rbmd_pkg::BYTE_W-1:0] mem_q [RingDepth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hw/rtl/rbmd_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbmd_seq: pointer and framing sequencer
// Holds the read/write pointers and fill count, walks the ring one entry
// per read/check pair, and stages each result in an output register.
// ----------------------------------------------------------------------------
module rbmd_seq #(
  parameter int unsigned RingDepth = rbmd_pkg::RING_DEPTH_DEF,
  parameter int unsigned MaxMsg    = rbmd_pkg::MAX_MSG_DEF,
  localparam int unsigned PtrW     = $clog2(RingDepth)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input item
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  input  logic [rbmd_pkg::BYTE_W-1:0] data_byte_i,
  input  logic [rbmd_pkg::LEN_W-1:0]  msg_length_i,
  // result item
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rbmd_pkg::BYTE_W-1:0] out_byte_o,
  output logic                        status_o,
  output logic                        last_o,
  // ring memory
  output logic                        ram_we_o,
  output logic [PtrW-1:0]             ram_waddr_o,
  output logic [rbmd_pkg::BYTE_W-1:0] ram_wdata_o,
  output logic                        ram_re_o,
  output logic [PtrW-1:0]             ram_raddr_o,
  input  logic [rbmd_pkg::BYTE_W-1:0] ram_rdata_i
);

  // compare width covers both the fill count and the length limit
  localparam int unsigned CmpW = (PtrW > 7) ? PtrW : 7;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(RingDepth - 1);
  localparam logic [CmpW-1:0] MsgLimit = CmpW'(MaxMsg);

  rbmd_pkg::rbmd_state_e state_q, state_d;

  logic [PtrW-1:0]                rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]                wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]                count_q, count_d;
  logic [rbmd_pkg::LEN_W-1:0]     len_q, len_d;
  logic [rbmd_pkg::LEN_W-1:0]     rem_q, rem_d;
  logic [rbmd_pkg::BYTE_W-1:0]    obyte_q, obyte_d;
  logic                           ostat_q, ostat_d;
  logic                           olast_q, olast_d;

  logic                           in_fire;
  logic                           len_bad;
  logic                           start_seen;
  logic                           enough_left;
  logic [PtrW-1:0]                rd_ptr_inc;
  logic [PtrW-1:0]                wr_ptr_inc;

  assign in_fire = in_valid_i && in_ready_o;

  // pointer advance with wrap at the ring end
  assign rd_ptr_inc = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
  assign wr_ptr_inc = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);

  // early length check against limit and fill count
  assign len_bad = (msg_length_i == '0)
                || (CmpW'(msg_length_i) >= MsgLimit)
                || (CmpW'(count_q) < CmpW'(msg_length_i));

  // scan result: marker bit and room for the rest of the message
  assign start_seen  = ram_rdata_i[rbmd_pkg::START_BIT];
  assign enough_left = CmpW'(count_q) >= CmpW'(len_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rbmd_pkg::ST_IDLE: begin
        if (in_fire && (command_i == rbmd_pkg::CMD_EXTRACT)) begin
          state_d = len_bad ? rbmd_pkg::ST_FAIL : rbmd_pkg::ST_SCAN_RD;
        end
      end
      rbmd_pkg::ST_SCAN_RD: begin
        state_d = rbmd_pkg::ST_SCAN_CHK;
      end
      rbmd_pkg::ST_SCAN_CHK: begin
        if (start_seen) begin
          state_d = enough_left ? rbmd_pkg::ST_OUT : rbmd_pkg::ST_FAIL;
        end else if (count_q == PtrW'(1)) begin
          state_d = rbmd_pkg::ST_FAIL;
        end else begin
          state_d = rbmd_pkg::ST_SCAN_RD;
        end
      end
      rbmd_pkg::ST_EMIT_RD: begin
        state_d = rbmd_pkg::ST_EMIT_CHK;
      end
      rbmd_pkg::ST_EMIT_CHK: begin
        state_d = rbmd_pkg::ST_OUT;
      end
      rbmd_pkg::ST_FAIL: begin
        state_d = rbmd_pkg::ST_OUT;
      end
      rbmd_pkg::ST_OUT: begin
        if (out_ready_i) begin
          state_d = (rem_q == '0) ? rbmd_pkg::ST_IDLE : rbmd_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_d = rbmd_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    count_d     = count_q;
    len_d       = len_q;
    rem_d       = rem_q;
    obyte_d     = obyte_q;
    ostat_d     = ostat_q;
    olast_d     = olast_q;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      rbmd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire) begin
          if (command_i == rbmd_pkg::CMD_APPEND) begin
            ram_we_o = 1'b1;
            wr_ptr_d = wr_ptr_inc;
            // full ring drops the oldest byte
            if (count_q == PtrLast) begin
              rd_ptr_d = rd_ptr_inc;
            end else begin
              count_d = count_q + PtrW'(1);
            end
          end else begin
            len_d = msg_length_i;
          end
        end
      end
      rbmd_pkg::ST_SCAN_RD: begin
        ram_re_o = 1'b1;
      end
      rbmd_pkg::ST_SCAN_CHK: begin
        // a marker without room behind it stays in the ring
        if (!(start_seen && !enough_left)) begin
          rd_ptr_d = rd_ptr_inc;
          count_d  = count_q - PtrW'(1);
        end
        if (start_seen && enough_left) begin
          obyte_d = ram_rdata_i;
          ostat_d = rbmd_pkg::STS_OK;
          olast_d = (len_q == rbmd_pkg::LEN_W'(1));
          rem_d   = len_q - rbmd_pkg::LEN_W'(1);
        end
      end
      rbmd_pkg::ST_EMIT_RD: begin
        ram_re_o = 1'b1;
      end
      rbmd_pkg::ST_EMIT_CHK: begin
        rd_ptr_d = rd_ptr_inc;
        count_d  = count_q - PtrW'(1);
        obyte_d  = ram_rdata_i;
        ostat_d  = rbmd_pkg::STS_OK;
        olast_d  = (rem_q == rbmd_pkg::LEN_W'(1));
        rem_d    = rem_q - rbmd_pkg::LEN_W'(1);
      end
      rbmd_pkg::ST_FAIL: begin
        obyte_d = '0;
        ostat_d = rbmd_pkg::STS_FAIL;
        olast_d = 1'b1;
        rem_d   = '0;
      end
      rbmd_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
        out_valid_o = 1'b0;
      end
    endcase
  end

  assign ram_waddr_o = wr_ptr_q;
  assign ram_wdata_o = data_byte_i;
  assign ram_raddr_o = rd_ptr_q;

  assign out_byte_o = obyte_q;
  assign status_o   = ostat_q;
  assign last_o     = olast_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rbmd_pkg::ST_IDLE;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      state_q  <= state_d;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    len_q   <= len_d;
    rem_q   <= rem_d;
    obyte_q <= obyte_d;
    ostat_q <= ostat_d;
    olast_q <= olast_d;
  end

endmodule

// ----- hw/rtl/ring_buffer_marker_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_marker_deframer: byte ring with marker-bit message extraction
// Appends bytes to a ring and pulls framed messages that start at a byte
// with bit 7 set.
// ----------------------------------------------------------------------------
// An append item leaves the block ready again on the next cycle. An extract
// item walks the ring through a memory with a registered read, so every ring
// entry it scans passes a read state that addresses the entry and a check
// state that checks or stages it. Each further byte of a found message passes
// result handoff, address and stage, and the sink may hold off each result. A
// failed extract gives a single item (byte zero, status fail, last set),
// staged in the fail state after an early length reject or after the scan.
// The block takes no new item until the last result of an extract has been
// taken.
module ring_buffer_marker_deframer #(
  parameter int unsigned RingDepth = rbmd_pkg::RING_DEPTH_DEF,
  parameter int unsigned MaxMsg    = rbmd_pkg::MAX_MSG_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  input  logic [rbmd_pkg::BYTE_W-1:0] data_byte_i,
  input  logic [rbmd_pkg::LEN_W-1:0]  msg_length_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rbmd_pkg::BYTE_W-1:0] out_byte_o,
  output logic                        status_o,
  output logic                        last_o
);

  localparam int unsigned PtrW = $clog2(RingDepth);

  logic                        ram_we;
  logic [PtrW-1:0]             ram_waddr;
  logic [rbmd_pkg::BYTE_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [PtrW-1:0]             ram_raddr;
  logic [rbmd_pkg::BYTE_W-1:0] ram_rdata;

  // sequencer with pointers and result register
  rbmd_seq #(
    .RingDepth (RingDepth),
    .MaxMsg    (MaxMsg)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .data_byte_i  (data_byte_i),
    .msg_length_i (msg_length_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .status_o     (status_o),
    .last_o       (last_o),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  // ring storage
  rbmd_ram #(
    .RingDepth (RingDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ----- hw/rtl/rbmd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbmd_checker: port-level checks for the deframer
// Watches the top-level handshakes and result fields over time.
// ----------------------------------------------------------------------------
module rbmd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        command_i,
  input logic [rbmd_pkg::BYTE_W-1:0] data_byte_i,
  input logic [rbmd_pkg::LEN_W-1:0]  msg_length_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [rbmd_pkg::BYTE_W-1:0] out_byte_o,
  input logic                        status_o,
  input logic                        last_o
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(status_o) && $stable(last_o))
    else $error("stalled result changed");

  // one item at a time: never taking input while a result is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // a failure is a single zero byte marked last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == rbmd_pkg::STS_FAIL) |-> (out_byte_o == '0) && last_o)
    else $error("failure result malformed");

  // zero length fails without touching the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (command_i == rbmd_pkg::CMD_EXTRACT) && (msg_length_i == '0)
      |-> ##2 out_valid_o && (status_o == rbmd_pkg::STS_FAIL))
    else $error("zero length extract did not fail");

  // an append gives no result and frees the input next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (command_i == rbmd_pkg::CMD_APPEND) |=> in_ready_o && !out_valid_o)
    else $error("append did not return to idle");

endmodule

bind ring_buffer_marker_deframer rbmd_checker u_rbmd_checker (.*);

// ----- tb/tb_ring_buffer_marker_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ring_buffer_marker_deframer: self-checking bench for the marker deframer
// Drives byte appends and message extracts with bursty valid and a stalling
// sink. A scoreboard keeps its own copy of the ring, works out the bytes each
// extract should deliver, and compares every result in order.
// ----------------------------------------------------------------------------
module tb_ring_buffer_marker_deframer;

  // one result of an extract
  typedef struct packed {
    logic [rbmd_pkg::BYTE_W-1:0] data;
    logic                        status;
    logic                        last;
  } deframe_result_t;

  // ring shadow plus the queue of results still to come
  class deframe_scoreboard;
    logic [rbmd_pkg::BYTE_W-1:0] ring_mem [rbmd_pkg::RING_DEPTH_DEF];
    int unsigned       rd_idx;
    int unsigned       wr_idx;
    deframe_result_t   pending_q [$];
    int unsigned       errors;

    function int unsigned held_bytes();
      return (wr_idx + rbmd_pkg::RING_DEPTH_DEF - rd_idx) % rbmd_pkg::RING_DEPTH_DEF;
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void push_failure();
      deframe_result_t r;
      r.data   = '0;
      r.status = rbmd_pkg::STS_FAIL;
      r.last   = 1'b1;
      pending_q.push_back(r);
    endfunction

    // update the ring shadow for one accepted item
    function void note_item(logic cmd, logic [rbmd_pkg::BYTE_W-1:0] data,
                            logic [rbmd_pkg::LEN_W-1:0] len);
      deframe_result_t r;
      logic [rbmd_pkg::BYTE_W-1:0] start_byte;
      bit found;
      int unsigned n;
      n = len;
      found = 1'b0;
      start_byte = '0;
      // append, dropping the oldest byte on a full ring
      if (cmd == rbmd_pkg::CMD_APPEND) begin
        ring_mem[wr_idx] = data;
        wr_idx = (wr_idx + 1) % rbmd_pkg::RING_DEPTH_DEF;
        if (wr_idx == rd_idx) rd_idx = (rd_idx + 1) % rbmd_pkg::RING_DEPTH_DEF;
        return;
      end
      // early reject on length
      if (n == 0 || n >= rbmd_pkg::MAX_MSG_DEF || held_bytes() < n) begin
        push_failure();
        return;
      end
      // skip bytes up to and including the first marker byte
      while (!found && held_bytes() > 0) begin
        start_byte = ring_mem[rd_idx];
        rd_idx = (rd_idx + 1) % rbmd_pkg::RING_DEPTH_DEF;
        if (start_byte[rbmd_pkg::START_BIT]) found = 1'b1;
      end
      if (!found) begin
        push_failure();
        return;
      end
      // too short after the marker: put the marker back
      if (held_bytes() < n - 1) begin
        rd_idx = (rd_idx + rbmd_pkg::RING_DEPTH_DEF - 1) % rbmd_pkg::RING_DEPTH_DEF;
        push_failure();
        return;
      end
      r.data   = start_byte;
      r.status = rbmd_pkg::STS_OK;
      r.last   = (n == 1);
      pending_q.push_back(r);
      for (int unsigned i = 1; i < n; i++) begin
        r.data = ring_mem[rd_idx];
        r.last = (i == n - 1);
        rd_idx = (rd_idx + 1) % rbmd_pkg::RING_DEPTH_DEF;
        pending_q.push_back(r);
      end
    endfunction

    // compare one delivered result with the oldest prediction
    function void check_item(logic [rbmd_pkg::BYTE_W-1:0] data, logic status, logic last);
      deframe_result_t want;
      if (pending_q.size() == 0) begin
        flag($sformatf("unexpected result byte %02h status %0d last %0d",
                       data, status, last));
        return;
      end
      want = pending_q.pop_front();
      if (want.data !== data || want.status !== status || want.last !== last)
        flag($sformatf("expected byte %02h status %0d last %0d, got %02h %0d %0d",
                       want.data, want.status, want.last, data, status, last));
    endfunction
  endclass

  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        in_valid     = 1'b0;
  logic                        in_ready_o;
  logic                        command      = rbmd_pkg::CMD_APPEND;
  logic [rbmd_pkg::BYTE_W-1:0] data_byte    = '0;
  logic [rbmd_pkg::LEN_W-1:0]  msg_length   = '0;
  logic                        out_valid_o;
  logic                        out_ready    = 1'b0;
  logic [rbmd_pkg::BYTE_W-1:0] out_byte_o;
  logic                        status_o;
  logic                        last_o;

  deframe_scoreboard sb = new;
  int unsigned       burst_left = 0;
  int unsigned       items_sent = 0;
  logic [8:0]        sink_cyc   = '0;

  ring_buffer_marker_deframer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .command_i   (command),
    .data_byte_i (data_byte),
    .msg_length_i(msg_length),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sink stall pattern, mode chosen by the top two bits of the cycle counter
  always @(posedge clk_i) begin
    sink_cyc <= sink_cyc + 1'b1;
    case (sink_cyc[8:7])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 1) == 0);
      2'd2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (sink_cyc[2:1] != 2'b11);
    endcase
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready)
      sb.check_item(out_byte_o, status_o, last_o);
  end

  // drive one item, idling between bursts
  task automatic send_item(input logic cmd, input logic [rbmd_pkg::BYTE_W-1:0] data,
                           input logic [rbmd_pkg::LEN_W-1:0] len);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 8);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    data_byte  <= data;
    msg_length <= len;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_item(cmd, data, len);
    burst_left--;
    items_sent++;
  endtask

  task automatic append_byte(input logic [rbmd_pkg::BYTE_W-1:0] data);
    send_item(rbmd_pkg::CMD_APPEND, data, rbmd_pkg::LEN_W'($urandom_range(0, 31)));
  endtask

  task automatic extract_msg(input logic [rbmd_pkg::LEN_W-1:0] len);
    send_item(rbmd_pkg::CMD_EXTRACT, rbmd_pkg::BYTE_W'($urandom_range(0, 255)), len);
  endtask

  // run limit
  initial begin
    #15_000_000;
    $display("tb: failure");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned random_from;
    int unsigned frame_len;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty ring and zero length
    extract_msg(5'd5);
    extract_msg(5'd0);
    // no marker byte, length one
    append_byte(8'h00);
    append_byte(8'h7f);
    extract_msg(5'd1);
    extract_msg(5'd1);
    // single byte message
    append_byte(8'h80);
    extract_msg(5'd1);
    // marker found but message short: marker goes back
    append_byte(8'h12);
    append_byte(8'hff);
    append_byte(8'h55);
    extract_msg(5'd3);
    append_byte(8'haa);
    extract_msg(5'd3);
    extract_msg(5'd16);

    // long run of non-marker bytes, then a long scan
    repeat (40) append_byte(rbmd_pkg::BYTE_W'($urandom_range(0, 127)));
    extract_msg(5'd1);
    // random bytes drained by longest messages
    repeat (60) append_byte(rbmd_pkg::BYTE_W'($urandom_range(0, 255)));
    repeat (3) extract_msg(5'd31);
    repeat (4) extract_msg(rbmd_pkg::LEN_W'($urandom_range(1, 4)));

    // random frames with noise
    random_from = items_sent;
    while (items_sent < random_from + 110) begin
      if ($urandom_range(0, 9) < 7) begin
        frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 31)
                                                : $urandom_range(1, 8);
        repeat ($urandom_range(0, 3))
          append_byte(rbmd_pkg::BYTE_W'($urandom_range(0, 127)));
        append_byte(rbmd_pkg::BYTE_W'(8'h80 | $urandom_range(0, 127)));
        repeat (frame_len - 1) append_byte(rbmd_pkg::BYTE_W'($urandom_range(0, 255)));
        case ($urandom_range(0, 5))
          0: extract_msg(rbmd_pkg::LEN_W'(frame_len + 1));
          1: extract_msg(rbmd_pkg::LEN_W'(frame_len - 1));
          default: extract_msg(rbmd_pkg::LEN_W'(frame_len));
        endcase
      end else if ($urandom_range(0, 1) == 0) begin
        append_byte(rbmd_pkg::BYTE_W'($urandom_range(0, 255)));
      end else begin
        extract_msg(rbmd_pkg::LEN_W'($urandom_range(0, 31)));
      end
    end
    in_valid <= 1'b0;

    // drain
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
